@@ src/arpm_pkg.sv @@
// shared types and constants of the rms and peak level meter
`default_nettype none
package arpm_pkg;
   localparam int CHANNELS_DEF  = 8;
   localparam int MAX_FRAMES_DEF = 65535;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int LEVEL_W = 24;
   localparam int SUM_W   = 62;
   localparam int COUNT_W = 16;
   localparam int FRAME_W = 64;
   localparam int DIN_W   = 48;
   localparam int DOUT_W  = 113;

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_TAKE   = 2'd1,
      REQ_RESET  = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_PEAK    = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // latch request fields
      logic accum;      // add sample into its channel
      logic clear_all;  // meter reset
      logic clear_blk;  // clear block accumulators
      logic div_start;  // start divide of current channel
      logic div_step;   // one quotient bit
      logic sqrt_start; // start root of quotient
      logic sqrt_step;  // one root digit pair
      logic best_upd;   // fold root into best
      logic chan_next;  // advance channel scan
      logic finish;     // commit rms, peak, frames
      logic take;       // capture take-peak answer and clear held peak
   } arpm_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [1:0] req_type;
      logic       eob;
      logic       frames_zero;
      logic       chan_last;
      logic       chan_has;
   } arpm_stat_type;
endpackage
`default_nettype wire

@@ src/arpm_datapath.sv @@
// datapath: channel accumulators, shared divider and square root unit
`default_nettype none
module arpm_datapath #(
   parameter int CHANNELS    = arpm_pkg::CHANNELS_DEF,
   parameter int MAX_FRAMES  = arpm_pkg::MAX_FRAMES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [arpm_pkg::DIN_W-1:0]  din,
   input  wire arpm_pkg::arpm_cmd_type      cmd,
   output arpm_pkg::arpm_stat_type          stat,
   output logic [arpm_pkg::DOUT_W-1:0]      dout
);
   localparam int SAMPLE_BITS = arpm_pkg::SAMPLE_BITS_DEF;
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MAG_W = SAMPLE_BITS;
   localparam int SQ_W  = 2 * MAG_W;
   localparam int S_W   = arpm_pkg::SUM_W;
   localparam int C_W   = arpm_pkg::COUNT_W;
   localparam int L_W   = arpm_pkg::LEVEL_W;
   localparam logic [S_W-1:0] SUM_MAX = {S_W{1'b1}};
   localparam logic [C_W-1:0] CNT_MAX = {C_W{1'b1}};
   localparam logic [16:0] MAXF = 17'(MAX_FRAMES > 65535 ? 65535 : MAX_FRAMES);

   // request fields
   logic [1:0]             rtype_ff;
   logic [2:0]             chan_ff;
   logic [SAMPLE_BITS-1:0] smp_ff;
   logic                   bad_ff, eob_ff;
   logic [15:0]            frames_ff;

   logic [S_W-1:0] sum_ff   [CHANNELS];
   logic [C_W-1:0] cnt_ff   [CHANNELS];
   logic [MAG_W-1:0] bpeak_ff, hpeak_ff;
   logic [L_W-1:0] rms_ff, best_ff;
   logic [63:0]    fcnt_ff;
   logic [CH_W-1:0] scan_ff;
   logic [arpm_pkg::DOUT_W-1:0] dout_ff;

   // shared restoring divider / square root registers
   logic [S_W-1:0] quo_ff, rem_ff, root_ff, bit_ff, val_ff;
   logic [C_W-1:0] div_ff;

   logic [SAMPLE_BITS-1:0] mag;
   logic [MAG_W-1:0]       din_mag;
   logic [SQ_W-1:0]        sq_ff;
   logic [CH_W-1:0]        ch_idx;
   logic                   ch_ok;
   logic [S_W:0]           sum_add;
   logic [S_W:0]           rem_sh;
   logic [S_W:0]           trial;

   assign mag    = smp_ff[SAMPLE_BITS-1] ? (~smp_ff + 1'b1) : smp_ff;
   assign din_mag = din[5 + SAMPLE_BITS - 1] ? (~din[5 +: SAMPLE_BITS] + 1'b1)
                                             : din[5 +: SAMPLE_BITS];
   assign ch_idx = CH_W'(chan_ff);
   assign ch_ok  = ({29'd0, chan_ff} < 32'(CHANNELS));
   assign sum_add = {1'b0, sum_ff[ch_idx]} + (S_W+1)'(sq_ff);
   assign rem_sh = {rem_ff, quo_ff[S_W-1]};
   assign trial  = {1'b0, root_ff} + {1'b0, bit_ff};

   // square of the incoming magnitude, registered before the add
   always_ff @(posedge clock) begin
      if (cmd.load)
         sq_ff <= {{MAG_W{1'b0}}, din_mag} * {{MAG_W{1'b0}}, din_mag};
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
         bpeak_ff <= '0;
         hpeak_ff <= '0;
         rms_ff   <= '0;
         fcnt_ff  <= '0;
         scan_ff  <= '0;
         best_ff  <= '0;
      end else begin
         // accumulate one good sample
         if (cmd.accum && !bad_ff && ch_ok) begin
            if (mag > bpeak_ff)
               bpeak_ff <= mag;
            if (cnt_ff[ch_idx] != CNT_MAX) begin
               sum_ff[ch_idx] <= sum_add[S_W] ? SUM_MAX : sum_add[S_W-1:0];
               cnt_ff[ch_idx] <= cnt_ff[ch_idx] + 1'b1;
            end
         end
         if (cmd.best_upd && root_ff[L_W-1:0] > best_ff && stat.chan_has)
            best_ff <= L_W'(root_ff);
         if (cmd.chan_next)
            scan_ff <= scan_ff + 1'b1;
         // commit block results
         if (cmd.finish) begin
            rms_ff   <= best_ff;
            if (bpeak_ff > hpeak_ff)
               hpeak_ff <= bpeak_ff;
            fcnt_ff  <= fcnt_ff + 64'((frames_ff > MAXF[15:0] && MAXF < 17'd65535)
                        ? MAXF[15:0] : frames_ff);
         end
         if (cmd.take)
            hpeak_ff <= '0;
         if (cmd.clear_blk) begin
            for (int i = 0; i < CHANNELS; i++) begin
               sum_ff[i] <= '0;
               cnt_ff[i] <= '0;
            end
            bpeak_ff <= '0;
            scan_ff  <= '0;
            best_ff  <= '0;
         end
      end
   end

   // request field latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rtype_ff  <= din[1:0];
         chan_ff   <= din[4:2];
         smp_ff    <= din[5 +: SAMPLE_BITS];
         bad_ff    <= din[29];
         eob_ff    <= din[30];
         frames_ff <= din[31 +: 16];
      end
   end

   // divider then root, one bit per step
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= sum_ff[scan_ff];
         div_ff <= cnt_ff[scan_ff];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= (S_W+1)'(div_ff)) begin
            rem_ff <= S_W'(rem_sh - (S_W+1)'(div_ff));
            quo_ff <= {quo_ff[S_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[S_W-1:0];
            quo_ff <= {quo_ff[S_W-2:0], 1'b0};
         end
      end else if (cmd.sqrt_start) begin
         val_ff  <= quo_ff;
         root_ff <= '0;
         bit_ff  <= S_W'(1) << (S_W - 2);
      end else if (cmd.sqrt_step) begin
         if ({1'b0, val_ff} >= trial) begin
            val_ff  <= val_ff - trial[S_W-1:0];
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // result beat: kind, rms, peak, frame total from the lowest bit up
   always_ff @(posedge clock) begin
      if (cmd.finish)
         dout_ff <= {fcnt_ff + 64'((frames_ff > MAXF[15:0] && MAXF < 17'd65535)
                     ? MAXF[15:0] : frames_ff),
                     L_W'((bpeak_ff > hpeak_ff) ? bpeak_ff : hpeak_ff),
                     best_ff, arpm_pkg::KIND_SUMMARY};
      else if (cmd.take)
         dout_ff <= {fcnt_ff, L_W'(hpeak_ff), rms_ff, arpm_pkg::KIND_PEAK};
   end

   assign dout             = dout_ff;
   assign stat.req_type    = rtype_ff;
   assign stat.eob         = eob_ff;
   assign stat.frames_zero = (frames_ff == 16'd0);
   assign stat.chan_last   = ({{(32-CH_W){1'b0}}, scan_ff} == 32'(CHANNELS - 1));
   assign stat.chan_has    = (cnt_ff[scan_ff] != '0);
endmodule
`default_nettype wire

@@ src/arpm_ctrl.sv @@
// controller: sequences a request through accumulate, divide and root
`default_nettype none
module arpm_ctrl #(
   parameter int SUM_BITS = arpm_pkg::SUM_W
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire arpm_pkg::arpm_stat_type stat,
   output arpm_pkg::arpm_cmd_type       cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_ACCUM, S_SCAN, S_DIV, S_SQST, S_SQRT, S_BEST,
      S_FINISH, S_CLEAR, S_SEND
   } state_type;

   localparam int STEP_W = $clog2(SUM_BITS + 1);
   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load = req_tvalid && req_tready;
      case (state_ff)
         S_DECODE: begin
            if (stat.req_type == arpm_pkg::REQ_RESET) cmd.clear_all = 1'b1;
            if (stat.req_type == arpm_pkg::REQ_TAKE)  cmd.take = 1'b1;
         end
         S_ACCUM:  cmd.accum = 1'b1;
         S_SCAN:   cmd.div_start = 1'b1;
         S_DIV:    cmd.div_step = 1'b1;
         S_SQST:   cmd.sqrt_start = 1'b1;
         S_SQRT:   cmd.sqrt_step = 1'b1;
         S_BEST: begin
            cmd.best_upd  = 1'b1;
            cmd.chan_next = !stat.chan_last;
         end
         S_FINISH: cmd.finish = 1'b1;
         S_CLEAR:  cmd.clear_blk = 1'b1;
         default:  ;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE) && !valid_ff;
   assign rsp_tvalid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (valid_ff && rsp_tready)
            valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) state_ff <= S_DECODE;
            S_DECODE: begin
               if (stat.req_type == arpm_pkg::REQ_TAKE) begin
                  valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (stat.req_type == arpm_pkg::REQ_SAMPLE)
                  state_ff <= S_ACCUM;
               else
                  state_ff <= S_IDLE;
            end
            S_ACCUM: begin
               if (!stat.eob)             state_ff <= S_IDLE;
               else if (stat.frames_zero) state_ff <= S_CLEAR;
               else                       state_ff <= S_SCAN;
            end
            S_SCAN: begin
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(SUM_BITS - 1)) state_ff <= S_SQST;
            end
            S_SQST: begin
               step_ff  <= '0;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(SUM_BITS / 2 - 1)) state_ff <= S_BEST;
            end
            S_BEST: state_ff <= stat.chan_last ? S_FINISH : S_SCAN;
            S_FINISH: begin
               valid_ff <= 1'b1;
               state_ff <= S_CLEAR;
            end
            S_CLEAR: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ src/audio_rms_peak_meter.sv @@
// top level of the rms and peak level meter
// Usage: one beat on req_ carries a request; req_tuser selects a sample,
// a take-peak read or a meter reset and flags a bad sample, req_tlast
// closes the block. Samples accumulate a sum of squares and count per
// channel plus a block peak. A sample beat with req_tlast and nonzero
// block_frames closes the block: for each channel the sum is divided by
// the count (62 one-bit steps) and a square root taken (31 steps) in one
// shared unit, one channel after another. The take-peak answer is valid
// in the cycle after its decode.
// Results go out on rsp_ as one beat held in an output register; a stalled
// receiver holds the beat and the next request waits until it is taken.
// Reset (synchronous, active high) clears all accumulators, held peak,
// stored rms and the frame counter; no clearing pass is needed.
`default_nettype none
module audio_rms_peak_meter #(
   parameter int CHANNELS         = arpm_pkg::CHANNELS_DEF,
   parameter int MAX_BLOCK_FRAMES = arpm_pkg::MAX_FRAMES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // channel[2:0], sample[26:3], block_frames[42:27], zero fill[47:43]
   input  wire logic [47:0]  req_tdata,
   // req_type[1:0], sample_bad[2]
   input  wire logic [2:0]   req_tuser,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // rms_level[23:0], peak_level[47:24], frame_total[111:48]
   output logic [111:0]      rsp_tdata,
   // result_kind
   output logic              rsp_tuser
);
   arpm_pkg::arpm_cmd_type  cmd;
   arpm_pkg::arpm_stat_type stat;
   logic [arpm_pkg::DIN_W-1:0]  din;
   logic [arpm_pkg::DOUT_W-1:0] dout;

   // request fields in datapath order
   assign din = {1'b0, req_tdata[42:27], req_tlast, req_tuser[2], req_tdata[26:3],
                 req_tdata[2:0], req_tuser[1:0]};

   arpm_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .stat, .cmd
   );

   arpm_datapath #(
      .CHANNELS(CHANNELS), .MAX_FRAMES(MAX_BLOCK_FRAMES)
   ) u_dp (
      .clock, .reset, .din(din), .cmd, .stat, .dout
   );

   assign rsp_tuser = dout[0];
   assign rsp_tdata = dout[112:1];

   // no new request while a result beat waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken with result pending");
   // result beat holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed under stall");
endmodule
`default_nettype wire
